// ===== hw/rtl/cmt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmt_pkg
// Shared types, sizes and codes of the counting multiset table unit.
// ----------------------------------------------------------------------------
package cmt_pkg;

  localparam int TABLE_SLOTS = 16;
  localparam int KEY_BITS    = 32;
  localparam int COUNT_BITS  = 16;

  localparam int DISTINCT_BITS = 5;
  localparam int STATUS_BITS   = 2;
  localparam int MODE_BITS     = 2;
  localparam int OCC_BITS      = $clog2(TABLE_SLOTS + 1);

  // Popularity tree geometry: one register stage for every two tree levels.
  localparam int TREE_LEVELS = $clog2(TABLE_SLOTS);
  localparam int TREE_LEAVES = 1 << TREE_LEVELS;
  localparam int TREE_STAGES = (TREE_LEVELS + 1) / 2;
  localparam int SCAN_BITS   = (TREE_STAGES > 1) ? $clog2(TREE_STAGES) : 1;

  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_MASK_BITS = 32;

  typedef logic [KEY_BITS-1:0]      key_t;
  typedef logic [COUNT_BITS-1:0]    count_t;
  typedef logic [MODE_BITS-1:0]     mode_t;
  typedef logic [STATUS_BITS-1:0]   status_t;
  typedef logic [DISTINCT_BITS-1:0] distinct_t;
  typedef logic [OCC_BITS-1:0]      occ_t;
  typedef logic [TABLE_SLOTS-1:0]   slot_vec_t;
  typedef logic [SCAN_BITS-1:0]     scan_cnt_t;

  localparam mode_t MODE_ADD    = 2'd0;
  localparam mode_t MODE_REMOVE = 2'd1;
  localparam mode_t MODE_QUERY  = 2'd2;

  localparam status_t STATUS_OK        = 2'd0;
  localparam status_t STATUS_FULL      = 2'd1;
  localparam status_t STATUS_NOT_FOUND = 2'd2;
  localparam status_t STATUS_SATURATED = 2'd3;

  // Word index of the key match mask register (paddr bit 2 upward).
  localparam logic [CFG_ADDR_BITS-3:0] REG_KEY_MATCH_MASK = '0;

  localparam count_t COUNT_MAX = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load_item;
    logic exec;
    logic load_out;
  } cmt_cmd_t;

  typedef struct packed {
    logic   valid;
    count_t count;
    key_t   key;
  } node_t;

  // The right node wins only on a strictly larger count, so ties keep the lower slot.
  function automatic node_t cmt_best(input node_t a, input node_t b);
    node_t res;
    if (b.valid && (!a.valid || (b.count > a.count))) begin
      res = b;
    end else begin
      res = a;
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/cmt_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmt_in_if
// Input channel: one operation word (mode and key) with valid/ready.
// ----------------------------------------------------------------------------
interface cmt_in_if;
  import cmt_pkg::*;

  logic  valid;
  logic  ready;
  mode_t mode;
  key_t  key;

  modport source (output valid, output mode, output key, input ready);
  modport sink   (input valid, input mode, input key, output ready);

endinterface

// ===== hw/rtl/cmt_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmt_out_if
// Result channel: one result word per operation with valid/ready.
// ----------------------------------------------------------------------------
interface cmt_out_if;
  import cmt_pkg::*;

  logic      valid;
  logic      ready;
  count_t    count_now;
  distinct_t distinct_entries;
  key_t      most_popular_key;
  logic      popular_valid;
  status_t   status;

  modport source (output valid, output count_now, output distinct_entries,
                  output most_popular_key, output popular_valid, output status,
                  input ready);
  modport sink   (input valid, input count_now, input distinct_entries,
                  input most_popular_key, input popular_valid, input status,
                  output ready);

endinterface

// ===== hw/rtl/cmt_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmt_cfg_regs
// APB-style register file holding the key match mask.
// ----------------------------------------------------------------------------
module cmt_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cmt_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  logic [cmt_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output logic [cmt_pkg::CFG_DATA_BITS-1:0]   prdata,
  output logic                                pready,
  output cmt_pkg::key_t                       key_mask
);
  import cmt_pkg::*;

  logic [CFG_MASK_BITS-1:0] mask_r;
  logic [CFG_MASK_BITS-1:0] mask_nxt;
  logic                     hit_mask;

  // The two low address bits take no part in decoding.
  assign hit_mask = (paddr[CFG_ADDR_BITS-1:2] == REG_KEY_MATCH_MASK);

  always_comb begin
    mask_nxt = mask_r;
    if (psel && penable && pwrite && hit_mask) begin
      mask_nxt = CFG_MASK_BITS'(pwdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '1;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  assign pready   = 1'b1;
  assign prdata   = hit_mask ? CFG_DATA_BITS'(mask_r) : '0;
  assign key_mask = KEY_BITS'(mask_r);

endmodule

// ===== hw/rtl/cmt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmt_ctrl
// Sequencer: accept, execute, tree scan and result hand-off.
// ----------------------------------------------------------------------------
module cmt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output cmt_pkg::cmt_cmd_t cmd
);
  import cmt_pkg::*;

  state_t    state_r;
  state_t    state_nxt;
  scan_cnt_t scan_cnt_r;
  scan_cnt_t scan_cnt_nxt;
  logic      out_valid_r;
  logic      out_valid_nxt;
  logic      scan_last;
  logic      out_free;

  assign scan_last = (scan_cnt_r == SCAN_BITS'(TREE_STAGES - 1));
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_last) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      ST_SCAN: begin
        cmd = '0;
      end
      ST_FIN: begin
        cmd.load_out = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_comb begin
    scan_cnt_nxt = '0;
    if (state_r == ST_SCAN && !scan_last) begin
      scan_cnt_nxt = scan_cnt_r + SCAN_BITS'(1);
    end
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scan_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hw/rtl/cmt_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmt_datapath
// Slot table, parallel key match, count update and popularity tree.
// ----------------------------------------------------------------------------
module cmt_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  cmt_pkg::cmt_cmd_t  cmd,
  input  cmt_pkg::mode_t     in_mode,
  input  cmt_pkg::key_t      in_key,
  input  cmt_pkg::key_t      key_mask,
  output cmt_pkg::count_t    res_count_now,
  output cmt_pkg::distinct_t res_distinct_entries,
  output cmt_pkg::key_t      res_most_popular_key,
  output logic               res_popular_valid,
  output cmt_pkg::status_t   res_status
);
  import cmt_pkg::*;

  // Slot table.
  key_t      slot_key_r   [TABLE_SLOTS];
  count_t    slot_count_r [TABLE_SLOTS];
  slot_vec_t slot_valid_r;
  slot_vec_t slot_valid_nxt;
  occ_t      occ_r;
  occ_t      occ_nxt;

  // Latched operation word.
  mode_t     item_mode_r;
  key_t      item_key_r;

  // Per-operation results.
  count_t    count_now_r;
  count_t    count_now_nxt;
  status_t   status_r;
  status_t   status_nxt;

  // Update decode.
  slot_vec_t match;
  slot_vec_t match_oh;
  slot_vec_t free_oh;
  slot_vec_t wr_oh;
  logic      hit;
  count_t    hit_count;
  count_t    new_count;
  logic      do_alloc;

  // Result word.
  count_t    out_count_r;
  distinct_t out_distinct_r;
  key_t      out_key_r;
  logic      out_pvalid_r;
  status_t   out_status_r;

  always_comb begin
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      match[i] = slot_valid_r[i] && (((slot_key_r[i] ^ item_key_r) & key_mask) == '0);
    end
  end

  // Lowest set bit picks the lowest matching slot and the lowest free slot.
  assign match_oh = match & ((~match) + slot_vec_t'(1));
  assign free_oh  = (~slot_valid_r) & (slot_valid_r + slot_vec_t'(1));
  assign hit      = |match;

  always_comb begin
    hit_count = '0;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      hit_count = hit_count | ({COUNT_BITS{match_oh[i]}} & slot_count_r[i]);
    end
  end

  always_comb begin
    count_now_nxt  = '0;
    status_nxt     = STATUS_OK;
    new_count      = hit_count;
    wr_oh          = '0;
    do_alloc       = 1'b0;
    slot_valid_nxt = slot_valid_r;
    occ_nxt        = occ_r;
    case (item_mode_r)
      MODE_ADD: begin
        if (hit) begin
          wr_oh = match_oh;
          if (hit_count == COUNT_MAX) begin
            status_nxt = STATUS_SATURATED;
          end else begin
            new_count = hit_count + COUNT_BITS'(1);
          end
          count_now_nxt = new_count;
        end else if (|free_oh) begin
          wr_oh          = free_oh;
          do_alloc       = 1'b1;
          new_count      = COUNT_BITS'(1);
          count_now_nxt  = COUNT_BITS'(1);
          slot_valid_nxt = slot_valid_r | free_oh;
          occ_nxt        = occ_r + OCC_BITS'(1);
        end else begin
          status_nxt = STATUS_FULL;
        end
      end
      MODE_REMOVE: begin
        if (!hit) begin
          status_nxt = STATUS_NOT_FOUND;
        end else begin
          wr_oh = match_oh;
          if (hit_count != '0) begin
            new_count = hit_count - COUNT_BITS'(1);
          end
          count_now_nxt = new_count;
          if (new_count == '0) begin
            slot_valid_nxt = slot_valid_r & ~match_oh;
            if (occ_r != '0) begin
              occ_nxt = occ_r - OCC_BITS'(1);
            end
          end
        end
      end
      default: begin
        count_now_nxt = hit_count;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      occ_r        <= '0;
    end else if (cmd.exec) begin
      slot_valid_r <= slot_valid_nxt;
      occ_r        <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (cmd.exec && wr_oh[i]) begin
        slot_count_r[i] <= new_count;
        if (do_alloc) begin
          slot_key_r[i] <= item_key_r;
        end
      end
    end
    if (cmd.load_item) begin
      item_mode_r <= in_mode;
      item_key_r  <= in_key;
    end
    if (cmd.exec) begin
      count_now_r <= count_now_nxt;
      status_r    <= status_nxt;
    end
  end

  // Popularity tree over the slots, registered after every second level.
  node_t tree_c [TREE_LEVELS+1][TREE_LEAVES];
  node_t tree_r [TREE_LEVELS+1][TREE_LEAVES];

  for (genvar lv = 0; lv <= TREE_LEVELS; lv++) begin : g_lvl
    for (genvar ix = 0; ix < TREE_LEAVES; ix++) begin : g_node
      if (lv == 0) begin : g_leaf
        if (ix < TABLE_SLOTS) begin : g_used
          assign tree_c[lv][ix].valid = slot_valid_r[ix];
          assign tree_c[lv][ix].count = slot_count_r[ix];
          assign tree_c[lv][ix].key   = slot_valid_r[ix] ? slot_key_r[ix] : '0;
        end else begin : g_pad
          assign tree_c[lv][ix] = '0;
        end
      end else if (ix < (TREE_LEAVES >> lv)) begin : g_cmp
        node_t lhs;
        node_t rhs;
        if ((lv - 1) > 0 && ((lv - 1) % 2) == 0) begin : g_from_reg
          assign lhs = tree_r[lv-1][2*ix];
          assign rhs = tree_r[lv-1][2*ix+1];
        end else begin : g_from_comb
          assign lhs = tree_c[lv-1][2*ix];
          assign rhs = tree_c[lv-1][2*ix+1];
        end
        assign tree_c[lv][ix] = cmt_best(lhs, rhs);
      end else begin : g_unused
        assign tree_c[lv][ix] = '0;
      end

      if (lv > 0 && ((lv % 2) == 0 || lv == TREE_LEVELS)) begin : g_reg
        always_ff @(posedge clk) begin
          tree_r[lv][ix] <= tree_c[lv][ix];
        end
      end else begin : g_noreg
        assign tree_r[lv][ix] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_count_r    <= count_now_r;
      out_status_r   <= status_r;
      out_distinct_r <= DISTINCT_BITS'(occ_r);
      out_key_r      <= tree_r[TREE_LEVELS][0].key;
      out_pvalid_r   <= tree_r[TREE_LEVELS][0].valid;
    end
  end

  assign res_count_now        = out_count_r;
  assign res_distinct_entries = out_distinct_r;
  assign res_most_popular_key = out_key_r;
  assign res_popular_valid    = out_pvalid_r;
  assign res_status           = out_status_r;

endmodule

// ===== hw/rtl/counting_multiset_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counting_multiset_table_unit
// Multiset of keys with counts in a fixed slot table, with masked key match.
//
//   Channel   Direction  Handshake            Word
//   in_ch     in         valid/ready          mode, key
//   out_ch    out        valid/ready          count_now, distinct_entries,
//                                             most_popular_key, popular_valid,
//                                             status
//   APB       in/out     psel/penable/pready  key_match_mask at byte address 0
//
// Each word passes through the execute step and the scan of the popularity
// tree, registered after every second level, before it reaches the result
// register; a new word is taken only once the previous one has left its final
// step for the output register.
// Reset (rst_n low, synchronous) empties the table and sets the mask to all ones.
// A result waits in the output register while out_ch stalls; the next word is
// accepted meanwhile and holds in its final step until the register is free.
// ----------------------------------------------------------------------------
module counting_multiset_table_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  cmt_in_if.sink                            in_ch,
  cmt_out_if.source                         out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cmt_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [cmt_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic [cmt_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                              pready
);
  import cmt_pkg::*;

  cmt_cmd_t cmd;
  key_t     key_mask;
  logic     in_ready;
  logic     out_valid;

  cmt_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .key_mask (key_mask)
  );

  cmt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  cmt_datapath u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .in_mode              (in_ch.mode),
    .in_key               (in_ch.key),
    .key_mask             (key_mask),
    .res_count_now        (out_ch.count_now),
    .res_distinct_entries (out_ch.distinct_entries),
    .res_most_popular_key (out_ch.most_popular_key),
    .res_popular_valid    (out_ch.popular_valid),
    .res_status           (out_ch.status)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule
